// ===== rtl/core/vhnn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhnn_pkg: shared types and constants of the voxel nearest-neighbor core
// Word layouts, command and status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package vhnn_pkg;

	localparam int unsigned TableSlotsDef   = 1024;
	localparam int unsigned PointsPerSlotDef = 32;
	localparam int unsigned QueueDepth       = 4;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_EVICT  = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic [2:0] ST_INSERTED   = 3'd0;
	localparam logic [2:0] ST_VOXEL_FULL = 3'd1;
	localparam logic [2:0] ST_TABLE_FULL = 3'd2;
	localparam logic [2:0] ST_MATCH      = 3'd3;
	localparam logic [2:0] ST_NO_MATCH   = 3'd4;
	localparam logic [2:0] ST_EVICT_DONE = 3'd5;

	localparam logic [2:0] CFG_VOXEL_EDGE   = 3'd0;
	localparam logic [2:0] CFG_POINT_LIMIT  = 3'd1;
	localparam logic [2:0] CFG_KEEP_RADIUS  = 3'd2;
	localparam logic [2:0] CFG_MATCH_RADIUS = 3'd3;
	localparam logic [2:0] CFG_LABEL_WEIGHT = 3'd4;

	localparam logic [15:0] EdgeReset   = 16'd256;
	localparam logic [5:0]  LimitReset  = 6'd20;
	localparam logic [22:0] KeepReset   = 23'd25600;
	localparam logic [22:0] MatchReset  = 23'd256;
	localparam logic [15:0] WeightReset = 16'd256;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic [7:0]         class_label;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [23:0] near_x;
		logic signed [23:0] near_y;
		logic signed [23:0] near_z;
		logic [7:0]         near_label;
		logic [10:0]        removed_count;
	} out_t;

	typedef struct packed {
		logic [15:0] voxel_edge;
		logic [5:0]  point_limit;
		logic [22:0] keep_radius;
		logic [22:0] match_radius;
		logic [15:0] label_weight;
	} cfg_t;

	// A classified word as the back end consumes it.
	typedef struct packed {
		in_t                item;
		logic signed [23:0] key_x;
		logic signed [23:0] key_y;
		logic signed [23:0] key_z;
	} work_t;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [7:0]         label;
	} pt_t;

endpackage

// ===== rtl/core/vhnn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhnn_front: command intake and voxel key quantizer
// Accepts a word, drops the unused command code and divides the three
// coordinates by the voxel edge, one quotient bit per cycle, toward zero.
// ----------------------------------------------------------------------------
module vhnn_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     voxel_edge,
	input  logic            in_valid,
	output logic            in_ready,
	input  vhnn_pkg::in_t   in_word,
	output logic            push_valid,
	input  logic            push_ready,
	output vhnn_pkg::work_t push_word
);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

	fstate_t        state_q;
	vhnn_pkg::in_t  item_q;
	logic [4:0]     step_q;
	logic [15:0]    div_q;
	logic [23:0]    mag_q [3];
	logic [15:0]    rem_q [3];
	logic [23:0]    quo_q [3];
	logic [23:0]    in_pos [3];
	logic [23:0]    key_pos [3];
	logic [16:0]    trial [3];
	logic [15:0]    rem_nx [3];
	logic           qbit [3];
	logic [23:0]    key [3];

	assign in_pos[0]  = in_word.pos_x;
	assign in_pos[1]  = in_word.pos_y;
	assign in_pos[2]  = in_word.pos_z;
	assign key_pos[0] = item_q.pos_x;
	assign key_pos[1] = item_q.pos_y;
	assign key_pos[2] = item_q.pos_z;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			trial[l] = {rem_q[l], mag_q[l][23]};
			if (trial[l] >= {1'b0, div_q}) begin
				rem_nx[l] = 16'(trial[l] - {1'b0, div_q});
				qbit[l]   = 1'b1;
			end else begin
				rem_nx[l] = trial[l][15:0];
				qbit[l]   = 1'b0;
			end
			key[l] = key_pos[l][23] ? (~quo_q[l] + 24'd1) : quo_q[l];
		end
	end

	assign in_ready          = (state_q == F_IDLE);
	assign push_valid        = (state_q == F_PUSH);
	assign push_word.item    = item_q;
	assign push_word.key_x   = key[0];
	assign push_word.key_y   = key[1];
	assign push_word.key_z   = key[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid && in_word.command != vhnn_pkg::CMD_NONE) begin
						state_q <= F_DIV;
						step_q  <= '0;
					end
				end
				F_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd23) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			item_q <= in_word;
			div_q  <= (voxel_edge == 16'd0) ? 16'd1 : voxel_edge;
			for (int l = 0; l < 3; l++) begin
				mag_q[l] <= in_pos[l][23] ? (~in_pos[l] + 24'd1) : in_pos[l];
				rem_q[l] <= '0;
				quo_q[l] <= '0;
			end
		end else if (state_q == F_DIV) begin
			for (int l = 0; l < 3; l++) begin
				mag_q[l] <= {mag_q[l][22:0], 1'b0};
				rem_q[l] <= rem_nx[l];
				quo_q[l] <= {quo_q[l][22:0], qbit[l]};
			end
		end
	end

endmodule

// ===== rtl/core/vhnn_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhnn_queue: short queue between the front and back ends
// Holds a few classified words so that each side stalls on its own.
// ----------------------------------------------------------------------------
module vhnn_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  vhnn_pkg::work_t push_word,
	output logic            pop_valid,
	input  logic            pop_ready,
	output vhnn_pkg::work_t pop_word
);

	localparam int unsigned PW = $clog2(vhnn_pkg::QueueDepth);

	vhnn_pkg::work_t entry_q [vhnn_pkg::QueueDepth];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != (PW+1)'(vhnn_pkg::QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_word   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ===== rtl/core/vhnn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhnn_back: voxel table engine
// Keeps the slot table and point store in memories and carries out insert,
// query and evict by sweeping the slot table one slot at a time.
// ----------------------------------------------------------------------------
module vhnn_back #(
	parameter int unsigned TABLE_SLOTS     = vhnn_pkg::TableSlotsDef,
	parameter int unsigned POINTS_PER_SLOT = vhnn_pkg::PointsPerSlotDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  vhnn_pkg::cfg_t  cfg,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  vhnn_pkg::work_t pop_word,
	output logic            out_valid,
	input  logic            out_ready,
	output vhnn_pkg::out_t  out_word
);

	localparam int unsigned SW = $clog2(TABLE_SLOTS);
	localparam int unsigned PB = (POINTS_PER_SLOT > 1) ? $clog2(POINTS_PER_SLOT) : 1;
	localparam int unsigned FW = $clog2(POINTS_PER_SLOT + 1);
	localparam int unsigned AW = SW + PB;
	localparam int unsigned PtsDepth = TABLE_SLOTS * (2 ** PB);

	typedef struct packed {
		logic               valid;
		logic signed [23:0] kx;
		logic signed [23:0] ky;
		logic signed [23:0] kz;
		logic [FW-1:0]      fill;
	} slot_t;

	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_SLOT_RD, B_SLOT_CHK, B_PT_RD, B_PT_SQ, B_PT_SUM,
		B_PT_MUL, B_PT_CMP, B_EV_CMP, B_FIN
	} bstate_t;

	slot_t          slot_mem [TABLE_SLOTS];
	vhnn_pkg::pt_t  point_mem [PtsDepth];

	bstate_t         state_q;
	logic [SW-1:0]   idx_q;
	logic [PB-1:0]   pidx_q;
	vhnn_pkg::work_t work_q;
	slot_t           slot_rd_q;
	slot_t           slot_cur_q;
	vhnn_pkg::pt_t   pt_rd_q;
	vhnn_pkg::pt_t   pt_cur_q;
	logic [4:0]      n_q;
	logic [49:0]     sqx_q, sqy_q, sqz_q;
	logic [16:0]     w_q;
	logic [49:0]     d2_q;
	logic [66:0]     prod_q;
	logic            found_q;
	logic [66:0]     best_prod_q;
	logic [49:0]     best_d2_q;
	logic [4:0]      best_n_q;
	logic [PB-1:0]   best_p_q;
	vhnn_pkg::pt_t   best_pt_q;
	logic            hit_q;
	logic [SW-1:0]   hit_slot_q;
	logic [FW-1:0]   hit_fill_q;
	logic            free_q;
	logic [SW-1:0]   free_slot_q;
	logic [10:0]     cnt_q;
	logic [45:0]     keep2_q;
	logic [45:0]     match2_q;
	logic            out_valid_q;
	vhnn_pkg::out_t  out_q;

	logic            last_slot;
	logic [24:0]     dkx, dky, dkz;
	logic            near_slot;
	logic [4:0]      n_cand;
	logic [24:0]     dx, dy, dz;
	logic [24:0]     ax, ay, az;
	logic            wmatch;
	logic            better;
	logic [6:0]      lim7;
	logic            vox_full;
	logic            slot_we;
	logic [SW-1:0]   slot_waddr;
	slot_t           slot_wdata;
	logic            pt_we;
	logic [AW-1:0]   pt_waddr;
	logic [AW-1:0]   pt_raddr;
	logic [SW-1:0]   ins_slot;
	vhnn_pkg::out_t  out_nx;

	assign last_slot = (idx_q == SW'(TABLE_SLOTS - 1));
	assign pop_ready = (state_q == B_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// Neighborhood test: each key offset must be -1, 0 or +1.
	assign dkx = {slot_rd_q.kx[23], slot_rd_q.kx} - {work_q.key_x[23], work_q.key_x};
	assign dky = {slot_rd_q.ky[23], slot_rd_q.ky} - {work_q.key_y[23], work_q.key_y};
	assign dkz = {slot_rd_q.kz[23], slot_rd_q.kz} - {work_q.key_z[23], work_q.key_z};

	function automatic logic [1:0] offs(input logic [24:0] d);
		logic [1:0] r;
		r = (d == '1) ? 2'd0 : ((d == '0) ? 2'd1 : 2'd2);
		return r;
	endfunction

	function automatic logic near1(input logic [24:0] d);
		return (d == '1) || (d == '0) || (d == 25'd1);
	endfunction

	assign near_slot = near1(dkx) && near1(dky) && near1(dkz);
	assign n_cand    = 5'(offs(dkx)) * 5'd9 + 5'(offs(dky)) * 5'd3 + 5'(offs(dkz));

	assign dx = {pt_rd_q.x[23], pt_rd_q.x} - {work_q.item.pos_x[23], work_q.item.pos_x};
	assign dy = {pt_rd_q.y[23], pt_rd_q.y} - {work_q.item.pos_y[23], work_q.item.pos_y};
	assign dz = {pt_rd_q.z[23], pt_rd_q.z} - {work_q.item.pos_z[23], work_q.item.pos_z};
	assign ax = dx[24] ? (~dx + 25'd1) : dx;
	assign ay = dy[24] ? (~dy + 25'd1) : dy;
	assign az = dz[24] ? (~dz + 25'd1) : dz;

	assign wmatch = (pt_rd_q.label == work_q.item.class_label) || (pt_rd_q.label == 8'd0)
		|| (work_q.item.class_label == 8'd0);

	// Ties go to the lower neighbor offset code, then the earlier point slot.
	assign better = !found_q || (prod_q < best_prod_q) ||
		((prod_q == best_prod_q) && ({n_q, pidx_q} < {best_n_q, best_p_q}));

	always_comb begin
		if (cfg.point_limit == 6'd0) begin
			lim7 = 7'd1;
		end else if ({1'b0, cfg.point_limit} > 7'(POINTS_PER_SLOT)) begin
			lim7 = 7'(POINTS_PER_SLOT);
		end else begin
			lim7 = {1'b0, cfg.point_limit};
		end
	end

	assign vox_full = (7'(hit_fill_q) >= lim7);
	assign ins_slot = hit_q ? hit_slot_q : free_slot_q;
	assign pt_raddr = {idx_q, pidx_q};

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = slot_cur_q;
		pt_we      = 1'b0;
		pt_waddr   = {ins_slot, PB'(0)};
		case (state_q)
			B_CLEAR: begin
				slot_we    = 1'b1;
				slot_wdata = '0;
			end
			B_EV_CMP: begin
				slot_we          = (d2_q > 50'(keep2_q));
				slot_wdata.valid = 1'b0;
			end
			B_FIN: begin
				if (work_q.item.command == vhnn_pkg::CMD_INSERT) begin
					slot_waddr       = ins_slot;
					slot_wdata.valid = 1'b1;
					slot_wdata.kx    = work_q.key_x;
					slot_wdata.ky    = work_q.key_y;
					slot_wdata.kz    = work_q.key_z;
					if (hit_q) begin
						slot_we         = !vox_full;
						pt_we           = !vox_full;
						slot_wdata.fill = hit_fill_q + 1'b1;
						pt_waddr        = {hit_slot_q, hit_fill_q[PB-1:0]};
					end else begin
						slot_we         = free_q;
						pt_we           = free_q;
						slot_wdata.fill = FW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		out_nx = '0;
		case (work_q.item.command)
			vhnn_pkg::CMD_INSERT: begin
				if (hit_q) begin
					out_nx.status = vox_full ? vhnn_pkg::ST_VOXEL_FULL :
						vhnn_pkg::ST_INSERTED;
				end else begin
					out_nx.status = free_q ? vhnn_pkg::ST_INSERTED :
						vhnn_pkg::ST_TABLE_FULL;
				end
			end
			vhnn_pkg::CMD_QUERY: begin
				if (found_q && best_d2_q < 50'(match2_q)) begin
					out_nx.status     = vhnn_pkg::ST_MATCH;
					out_nx.near_x     = best_pt_q.x;
					out_nx.near_y     = best_pt_q.y;
					out_nx.near_z     = best_pt_q.z;
					out_nx.near_label = best_pt_q.label;
				end else begin
					out_nx.status = vhnn_pkg::ST_NO_MATCH;
				end
			end
			default: begin
				out_nx.status        = vhnn_pkg::ST_EVICT_DONE;
				out_nx.removed_count = cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd_q <= slot_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			point_mem[pt_waddr] <= work_q.item.class_label == 8'd0 ?
				{work_q.item.pos_x, work_q.item.pos_y, work_q.item.pos_z, 8'd0} :
				{work_q.item.pos_x, work_q.item.pos_y, work_q.item.pos_z,
				 work_q.item.class_label};
		end
		pt_rd_q <= point_mem[pt_raddr];
	end

	// Squared radii follow the registers; the user must change them only while idle, which the block does not enforce.
	always_ff @(posedge clk) begin
		keep2_q  <= 46'(cfg.keep_radius) * 46'(cfg.keep_radius);
		match2_q <= 46'(cfg.match_radius) * 46'(cfg.match_radius);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != B_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					if (last_slot) begin
						idx_q   <= '0;
						state_q <= B_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				B_IDLE: begin
					if (pop_valid && !out_valid_q) begin
						idx_q   <= '0;
						state_q <= B_SLOT_RD;
					end
				end
				B_SLOT_RD: state_q <= B_SLOT_CHK;
				B_SLOT_CHK: begin
					if (slot_rd_q.valid &&
						((work_q.item.command == vhnn_pkg::CMD_EVICT) ||
						 ((work_q.item.command == vhnn_pkg::CMD_QUERY) && near_slot &&
						  slot_rd_q.fill != '0))) begin
						state_q <= B_PT_RD;
					end else if (last_slot) begin
						state_q <= B_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= B_SLOT_RD;
					end
				end
				B_PT_RD: state_q <= B_PT_SQ;
				B_PT_SQ: state_q <= B_PT_SUM;
				B_PT_SUM: begin
					state_q <= (work_q.item.command == vhnn_pkg::CMD_EVICT) ?
						B_EV_CMP : B_PT_MUL;
				end
				B_PT_MUL: state_q <= B_PT_CMP;
				B_PT_CMP: begin
					if (FW'(pidx_q) + FW'(1) < slot_cur_q.fill) begin
						state_q <= B_PT_RD;
					end else if (last_slot) begin
						state_q <= B_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= B_SLOT_RD;
					end
				end
				B_EV_CMP: begin
					if (last_slot) begin
						state_q <= B_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= B_SLOT_RD;
					end
				end
				B_FIN: begin
					out_valid_q <= 1'b1;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				work_q  <= pop_word;
				found_q <= 1'b0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
				cnt_q   <= '0;
				pidx_q  <= '0;
			end
			B_SLOT_CHK: begin
				slot_cur_q <= slot_rd_q;
				n_q        <= n_cand;
				pidx_q     <= '0;
				if (slot_rd_q.valid && slot_rd_q.kx == work_q.key_x &&
					slot_rd_q.ky == work_q.key_y && slot_rd_q.kz == work_q.key_z) begin
					hit_q      <= 1'b1;
					hit_slot_q <= idx_q;
					hit_fill_q <= slot_rd_q.fill;
				end
				if (!slot_rd_q.valid && !free_q) begin
					free_q      <= 1'b1;
					free_slot_q <= idx_q;
				end
			end
			B_PT_SQ: begin
				pt_cur_q <= pt_rd_q;
				sqx_q    <= 50'(ax) * 50'(ax);
				sqy_q    <= 50'(ay) * 50'(ay);
				sqz_q    <= 50'(az) * 50'(az);
				w_q      <= wmatch ? {1'b0, cfg.label_weight} : 17'd256;
			end
			B_PT_SUM: d2_q <= sqx_q + sqy_q + sqz_q;
			B_PT_MUL: prod_q <= 67'(d2_q) * 67'(w_q);
			B_PT_CMP: begin
				pidx_q <= pidx_q + 1'b1;
				if (better) begin
					found_q     <= 1'b1;
					best_prod_q <= prod_q;
					best_d2_q   <= d2_q;
					best_n_q    <= n_q;
					best_p_q    <= pidx_q;
					best_pt_q   <= pt_cur_q;
				end
			end
			B_EV_CMP: begin
				if (d2_q > 50'(keep2_q)) begin
					cnt_q <= cnt_q + 11'd1;
				end
			end
			B_FIN: out_q <= out_nx;
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/voxel_hash_nearest_neighbor_core.sv =====
`timescale 1ns / 1ps
// Flow: the front end takes a word and runs a 24-step key divider; the back end then
// sweeps every table slot, reading and checking each; per stored point of each
// neighboring voxel a query reads, squares, sums, weights and compares, and per
// occupied slot an evict reads, squares, sums and compares its first point.
// Throughput: one word per back-end sweep, the next only once the last result is taken.
// Reset: configuration registers take defaults; a pass clears every slot, and no word enters the back end meanwhile.
// ----------------------------------------------------------------------------
// voxel_hash_nearest_neighbor_core: voxel table nearest-neighbor core
// Configuration registers, key quantizing front end, queue and table engine.
// ----------------------------------------------------------------------------
module voxel_hash_nearest_neighbor_core #(
	parameter int unsigned TABLE_SLOTS     = vhnn_pkg::TableSlotsDef,
	parameter int unsigned POINTS_PER_SLOT = vhnn_pkg::PointsPerSlotDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vhnn_pkg::in_t  in_word,
	output logic           out_valid,
	input  logic           out_ready,
	output vhnn_pkg::out_t out_word,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [22:0]    cfg_data
);

	vhnn_pkg::cfg_t  cfg_q;
	logic            push_valid;
	logic            push_ready;
	vhnn_pkg::work_t push_word;
	logic            pop_valid;
	logic            pop_ready;
	vhnn_pkg::work_t pop_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voxel_edge   <= vhnn_pkg::EdgeReset;
			cfg_q.point_limit  <= vhnn_pkg::LimitReset;
			cfg_q.keep_radius  <= vhnn_pkg::KeepReset;
			cfg_q.match_radius <= vhnn_pkg::MatchReset;
			cfg_q.label_weight <= vhnn_pkg::WeightReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				vhnn_pkg::CFG_VOXEL_EDGE:   cfg_q.voxel_edge   <= cfg_data[15:0];
				vhnn_pkg::CFG_POINT_LIMIT:  cfg_q.point_limit  <= cfg_data[5:0];
				vhnn_pkg::CFG_KEEP_RADIUS:  cfg_q.keep_radius  <= cfg_data;
				vhnn_pkg::CFG_MATCH_RADIUS: cfg_q.match_radius <= cfg_data;
				vhnn_pkg::CFG_LABEL_WEIGHT: cfg_q.label_weight <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	vhnn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.voxel_edge (cfg_q.voxel_edge),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word)
	);

	vhnn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_word   (pop_word)
	);

	vhnn_back #(
		.TABLE_SLOTS     (TABLE_SLOTS),
		.POINTS_PER_SLOT (POINTS_PER_SLOT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_word  (pop_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
